FILE: design/tdlr_pkg.sv
// Package: shared constants and the controller/datapath command and status types.
`default_nettype none
package tdlr_pkg;

   // Store geometry
   localparam int PLY_SLOTS = 64;
   localparam int PLY_AW    = $clog2(PLY_SLOTS);
   localparam int CNT_W     = $clog2(PLY_SLOTS + 1);

   // Fixed-point constants
   localparam int LAM_W   = 17;
   localparam int VAL_W   = 16;
   localparam int RR_W    = 18;
   localparam logic [LAM_W-1:0]        LAM_ONE  = 17'd65536;
   localparam logic signed [RR_W-1:0]  Q_ONE    = 18'sd16384;
   localparam logic signed [RR_W-1:0]  Q_MONE   = -18'sd16384;
   localparam logic signed [RR_W-1:0]  RR_MAX   = 18'sd131071;
   localparam logic signed [RR_W-1:0]  RR_MIN   = -18'sd131072;

   // Outcome codes
   localparam logic signed [1:0] OC_LOSS = 2'b11;
   localparam logic signed [1:0] OC_DRAW = 2'b00;
   localparam logic signed [1:0] OC_WIN  = 2'b01;
   localparam logic signed [1:0] OC_BAD  = 2'b10;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic              load_we;
      logic [PLY_AW-1:0] wr_addr;
      logic              capture;
      logic              rd_en;
      logic [PLY_AW-1:0] rd_addr;
      logic              mul_en;
      logic              step_en;
      logic              first;
      logic [PLY_AW-1:0] ply_idx;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

FILE: design/tdlr_if.sv
// Interfaces: request, response and control-register channels.
`default_nettype none

interface tdlr_req_if;
   logic              valid;
   logic              ready;
   logic              mover_side;
   logic signed [15:0] leaf_value;
   logic signed [1:0] final_outcome;
   logic              final_side;
   logic              last_ply;
   modport source (output valid, mover_side, leaf_value, final_outcome, final_side,
                   last_ply, input ready);
   modport sink   (input valid, mover_side, leaf_value, final_outcome, final_side,
                   last_ply, output ready);
endinterface

interface tdlr_rsp_if;
   logic               valid;
   logic               ready;
   logic [5:0]         ply_number;
   logic signed [15:0] return_target;
   logic signed [1:0]  outcome_target;
   logic               last_label;
   modport source (output valid, ply_number, return_target, outcome_target, last_label,
                   input ready);
   modport sink   (input valid, ply_number, return_target, outcome_target, last_label,
                   output ready);
endinterface

interface tdlr_csr_if;
   logic        valid;
   logic        ready;
   logic [16:0] lambda_weight;
   modport source (output valid, lambda_weight, input ready);
   modport sink   (input valid, lambda_weight, output ready);
endinterface

`default_nettype wire

FILE: design/td_lambda_return_labeler.sv
// Top level: TD(lambda) return labeler, controller plus datapath.
//
//   channel  | dir | payload
//   req_if   | in  | mover_side, leaf_value, final_outcome, final_side, last_ply
//   rsp_if   | out | ply_number, return_target, outcome_target, last_label
//   csr_if   | in  | lambda_weight (always ready)
//
// Requests are accepted while the controller is in its load state. After the last
// ply request the walk reads the first store entry, then takes each ply through a
// multiply step and an accumulate-and-emit step, set by the product register in
// the return recursion: each ply's return feeds the products of the next ply down.
// A label waits in the output register; a stalled response holds the walk in
// its accumulate step. Requests are refused during the walk.
// Synchronous reset clears the control state, the running return and lambda to 1.0.
`default_nettype none
module td_lambda_return_labeler
   import tdlr_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   tdlr_req_if.sink   req_if,
   tdlr_rsp_if.source rsp_if,
   tdlr_csr_if.sink   csr_if
);

   cmd_type    cmd;
   status_type status;

   tdlr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_ply),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tdlr_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if),
      .cmd    (cmd),
      .status (status)
   );

endmodule
`default_nettype wire

FILE: design/tdlr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module tdlr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: design/tdlr_ctrl.sv
// Controller: load sequencing, backward walk and output-register flow control.
`default_nettype none
module tdlr_ctrl
   import tdlr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_last,
   output      logic       req_ready,
   input  wire status_type status,
   output      cmd_type    cmd
);

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_ACC  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PLY_AW-1:0] t_ff, t_in;
   logic              first_ff, first_in;
   logic              accept;
   logic              has_room;
   logic [CNT_W-1:0]  n_plies;

   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_valid && req_ready;
   assign has_room  = (count_ff < CNT_W'(PLY_SLOTS));
   // plies in this game once the current request is counted
   assign n_plies   = has_room ? count_ff + CNT_W'(1) : count_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      t_in     = t_ff;
      first_in = first_ff;
      cmd      = '0;
      cmd.wr_addr = count_ff[PLY_AW-1:0];
      cmd.rd_addr = t_ff;
      cmd.ply_idx = t_ff;
      cmd.first   = first_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cmd.load_we = has_room;
               count_in    = n_plies;
               if (req_last) begin
                  cmd.capture = 1'b1;
                  count_in    = '0;
                  t_in        = PLY_AW'(n_plies - CNT_W'(1));
                  first_in    = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            // emit a label once the output register can take it
            if (status.out_free) begin
               cmd.step_en = 1'b1;
               first_in    = 1'b0;
               if (t_ff == '0) begin
                  state_in = ST_LOAD;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = t_ff - PLY_AW'(1);
                  t_in        = t_ff - PLY_AW'(1);
                  state_in    = ST_MUL;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         t_ff     <= '0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         t_ff     <= t_in;
         first_ff <= first_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/tdlr_dp.sv
// Datapath: ply store, lambda register, return recursion and output register.
`default_nettype none
module tdlr_dp
   import tdlr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   tdlr_req_if.sink        req_if,
   tdlr_rsp_if.source      rsp_if,
   tdlr_csr_if.sink        csr_if,
   input  wire cmd_type    cmd,
   output      status_type status
);

   localparam int PV_W  = LAM_W + 1 + VAL_W;   // weight times value
   localparam int PU_W  = LAM_W + 1 + RR_W;    // lambda times return
   localparam int SUM_W = PU_W + 1;
   localparam int Q_W   = SUM_W - 16;
   localparam int ENT_W = VAL_W + 1;

   // Lambda register
   logic [LAM_W-1:0] lambda_ff;
   assign csr_if.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         lambda_ff <= LAM_ONE;
      end else if (csr_if.valid) begin
         lambda_ff <= csr_if.lambda_weight;
      end
   end

   // Ply store: {side, value}
   logic [ENT_W-1:0] rdata;
   tdlr_ram #(.WIDTH(ENT_W), .DEPTH(PLY_SLOTS)) u_store (
      .clock (clock),
      .we    (cmd.load_we),
      .waddr (cmd.wr_addr),
      .wdata ({req_if.mover_side, req_if.leaf_value}),
      .re    (cmd.rd_en),
      .raddr (cmd.rd_addr),
      .rdata (rdata)
   );

   // Game outcome, latched on the last request; -2 saturates to loss
   logic signed [1:0] fo_ff;
   logic              fside_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         fo_ff    <= (req_if.final_outcome == OC_BAD) ? OC_LOSS : req_if.final_outcome;
         fside_ff <= req_if.final_side;
      end
   end

   // Entry of ply t+1, kept from the previous step
   logic [ENT_W-1:0] prev_ff;
   always_ff @(posedge clock) begin
      if (cmd.step_en) begin
         prev_ff <= rdata;
      end
   end

   // Products
   logic [LAM_W-1:0]          lam_eff;
   logic [LAM_W-1:0]          wl;
   logic signed [PV_W-1:0]    prod_v_ff;
   logic signed [PU_W-1:0]    prod_u_ff;
   logic signed [RR_W-1:0]    rr_ff, rr_in;
   assign lam_eff = (lambda_ff > LAM_ONE) ? LAM_ONE : lambda_ff;
   assign wl      = LAM_ONE - lam_eff;
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_v_ff <= $signed({1'b0, wl}) * $signed(prev_ff[VAL_W-1:0]);
         prod_u_ff <= $signed({1'b0, lam_eff}) * rr_ff;
      end
   end

   // Sum, round half up, sign flip and saturation
   logic signed [SUM_W-1:0] sum_r;
   logic signed [Q_W-1:0]   q;
   logic signed [Q_W:0]     u;
   logic                    cur_side;
   logic signed [1:0]       oc;
   logic signed [RR_W-1:0]  u_first;
   logic signed [RR_W-1:0]  u_rec;
   assign cur_side = rdata[VAL_W];
   assign oc       = (cur_side == fside_ff) ? fo_ff : -fo_ff;
   assign sum_r    = SUM_W'(prod_v_ff) + SUM_W'(prod_u_ff) + SUM_W'(32768);
   assign q        = sum_r[SUM_W-1:16];
   assign u        = (cur_side != prev_ff[VAL_W]) ? -(Q_W+1)'(q) : (Q_W+1)'(q);

   always_comb begin
      case (oc)
         OC_WIN:  u_first = Q_ONE;
         OC_LOSS: u_first = Q_MONE;
         default: u_first = '0;
      endcase
      if (u > (Q_W+1)'(RR_MAX)) begin
         u_rec = RR_MAX;
      end else if (u < (Q_W+1)'(RR_MIN)) begin
         u_rec = RR_MIN;
      end else begin
         u_rec = RR_W'(u);
      end
      rr_in = cmd.first ? u_first : u_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rr_ff <= '0;
      end else if (cmd.step_en) begin
         rr_ff <= rr_in;
      end
   end

   // Output register
   logic                     valid_ff;
   logic [5:0]               ply_ff;
   logic signed [VAL_W-1:0]  ret_ff;
   logic signed [1:0]        oc_ff;
   logic                     last_ff;
   logic signed [VAL_W-1:0]  ret_clamped;
   assign ret_clamped = (rr_in > Q_ONE)  ? VAL_W'(Q_ONE)  :
                        (rr_in < Q_MONE) ? VAL_W'(Q_MONE) : VAL_W'(rr_in);
   assign status.out_free = !valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.step_en) begin
         valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step_en) begin
         ply_ff  <= 6'(cmd.ply_idx);
         ret_ff  <= ret_clamped;
         oc_ff   <= oc;
         last_ff <= (cmd.ply_idx == '0);
      end
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.ply_number     = ply_ff;
   assign rsp_if.return_target  = ret_ff;
   assign rsp_if.outcome_target = oc_ff;
   assign rsp_if.last_label     = last_ff;

endmodule
`default_nettype wire

FILE: verif/td_lambda_return_labeler_tb.sv
// Testbench: random and directed games through the TD(lambda) labeler, checked by a scoreboard.
`default_nettype none
module td_lambda_return_labeler_tb;
   import tdlr_pkg::*;

   localparam int      CYCLE_LIMIT = 400000;
   localparam int      RANDOM_PLIES = 430;
   localparam longint  LAM_FULL = LAM_ONE;
   localparam longint  RET_ONE  = Q_ONE;
   localparam longint  RET_HI   = RR_MAX;
   localparam longint  RET_LO   = RR_MIN;

   // One label as the block emits it
   typedef struct packed {
      logic [5:0]         ply;
      logic signed [15:0] ret;
      logic signed [1:0]  oc;
      logic               last;
   } label_t;

   // Holds the game being loaded and the labels it must produce
   class label_board;
      bit                 sides [PLY_SLOTS];
      logic signed [15:0] vals [PLY_SLOTS];
      int                 count;
      longint             running;
      longint             lam_q16;
      label_t             expected [$];
      int                 errors;
      int                 labels_checked;
      int                 plies_dropped;
      int                 games;

      function new();
         count          = 0;
         running        = 0;
         lam_q16        = LAM_FULL;
         errors         = 0;
         labels_checked = 0;
         plies_dropped  = 0;
         games          = 0;
      endfunction

      function void set_lambda(logic [16:0] w);
         lam_q16 = w;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      function longint clip(longint x, longint lo, longint hi);
         if (x < lo) return lo;
         if (x > hi) return hi;
         return x;
      endfunction

      // Store one accepted request; on the last ply, run the backward walk
      function void absorb_ply(bit side, logic signed [15:0] leaf,
                               logic signed [1:0] fo_raw, bit fside, bit last);
         logic signed [1:0] fo;
         logic signed [1:0] oc;
         longint            lam;
         longint            p;
         longint            u;
         int                t;
         label_t            lbl;
         fo = (fo_raw == OC_BAD) ? OC_LOSS : fo_raw;
         if (count < PLY_SLOTS) begin
            sides[count] = side;
            vals[count]  = leaf;
            count++;
         end else begin
            plies_dropped++;
         end
         if (!last) return;
         games++;
         lam = (lam_q16 > LAM_FULL) ? LAM_FULL : lam_q16;
         for (t = count - 1; t >= 0; t--) begin
            oc = (sides[t] == fside) ? fo : -fo;
            if (t == count - 1) begin
               u = longint'(oc) * RET_ONE;
            end else begin
               p = (LAM_FULL - lam) * longint'(vals[t + 1]) + lam * running;
               // round half up, then floor
               u = (p + 32768) >>> 16;
               if (sides[t] != sides[t + 1]) u = -u;
            end
            running  = clip(u, RET_LO, RET_HI);
            lbl.ply  = t[5:0];
            lbl.ret  = 16'(clip(running, -RET_ONE, RET_ONE));
            lbl.oc   = oc;
            lbl.last = (t == 0);
            expected.push_back(lbl);
         end
         count = 0;
      endfunction

      function void report(string what, longint exp_v, longint act_v);
         errors++;
         if (errors <= 200)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
      endfunction

      // Compare one accepted label with the oldest expectation
      function void check_label(label_t got);
         label_t exp_l;
         if (expected.size() == 0) begin
            errors++;
            $display("%0t: unexpected label: expected none, actual ply %0d return %0d",
                     $time, got.ply, got.ret);
            return;
         end
         exp_l = expected.pop_front();
         labels_checked++;
         if (got.ply != exp_l.ply) report("ply_number", exp_l.ply, got.ply);
         if (got.ret != exp_l.ret) report("return_target", exp_l.ret, got.ret);
         if (got.oc != exp_l.oc) report("outcome_target", exp_l.oc, got.oc);
         if (got.last != exp_l.last) report("last_label", exp_l.last, got.last);
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;
   int   cycles;
   int   stall_left;
   int   plies_sent;
   int   lambda_writes;
   label_board board;

   tdlr_req_if req_ch ();
   tdlr_rsp_if rsp_ch ();
   tdlr_csr_if csr_ch ();

   td_lambda_return_labeler dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Leaf value with extra weight on the extremes
   function automatic logic signed [15:0] pick_leaf();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'sh7FFF;
      if (r < 20) return 16'sh8000;
      if (r < 25) return 16'sh0000;
      return 16'($urandom);
   endfunction

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("td_lambda_return_labeler_tb NOT OK");
         $finish;
      end
   end

   // Response-side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   // Label monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_label({rsp_ch.ply_number, rsp_ch.return_target,
                            rsp_ch.outcome_target, rsp_ch.last_label});
   end

   task automatic write_lambda(input logic [16:0] w);
      csr_ch.valid         <= 1'b1;
      csr_ch.lambda_weight <= w;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      board.set_lambda(w);
      lambda_writes++;
   endtask

   // Optional gap, then one request held until accepted
   task automatic offer_ply(input bit side, input logic signed [15:0] leaf,
                            input logic [1:0] fo, input bit fside, input bit last);
      int g;
      g = calm ? 0 : pick_gap();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.mover_side    <= side;
      req_ch.leaf_value    <= leaf;
      req_ch.final_outcome <= fo;
      req_ch.final_side    <= fside;
      req_ch.last_ply      <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.absorb_ply(side, leaf, fo, fside, last);
      plies_sent++;
   endtask

   // A game of n requests with random content; the final fields ride on every request
   task automatic random_game(input int n);
      int i;
      for (i = 0; i < n; i++)
         offer_ply(1'($urandom), pick_leaf(), 2'($urandom), 1'($urandom), i == n - 1);
   endtask

   // Drop the request, wait for every label, then let the walk drain before touching lambda
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [16:0] pick_lambda();
      case ($urandom_range(0, 7))
         0: return 17'd0;
         1: return LAM_ONE;
         2: return 17'h1FFFF;
         3: return 17'd1;
         4: return 17'd65535;
         5: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic int pick_length(input bit first);
      int r;
      if (first) return 66;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 8);
      if (r < 92) return $urandom_range(9, 40);
      return $urandom_range(60, 70);
   endfunction

   // Main sequence
   initial begin
      int  games_left;
      bit  first;
      board                = new();
      cycles               = 0;
      plies_sent           = 0;
      lambda_writes        = 0;
      calm                 = 1'b0;
      first                = 1'b1;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.mover_side    <= 1'b0;
      req_ch.leaf_value    <= '0;
      req_ch.final_outcome <= OC_DRAW;
      req_ch.final_side    <= 1'b0;
      req_ch.last_ply      <= 1'b0;
      csr_ch.valid         <= 1'b0;
      csr_ch.lambda_weight <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single-ply games at reset lambda, outcome pattern -2
      offer_ply(1'b0, 16'sh7FFF, OC_WIN, 1'b0, 1'b1);
      offer_ply(1'b1, 16'sh8000, OC_BAD, 1'b0, 1'b1);
      settle();

      // Pure bootstrap: returns follow the next leaf value, alternating movers
      write_lambda(17'd0);
      offer_ply(1'b0, 16'sh8000, OC_WIN, 1'b0, 1'b0);
      offer_ply(1'b1, 16'sh7FFF, OC_BAD, 1'b1, 1'b0);
      offer_ply(1'b0, 16'sh8000, OC_LOSS, 1'b0, 1'b0);
      offer_ply(1'b1, 16'sh0000, OC_DRAW, 1'b1, 1'b1);
      // same mover throughout, no sign flips
      offer_ply(1'b0, 16'sh7FFF, OC_LOSS, 1'b1, 1'b0);
      offer_ply(1'b0, 16'sh7FFF, OC_DRAW, 1'b0, 1'b0);
      offer_ply(1'b0, 16'sh8000, OC_BAD, 1'b1, 1'b0);
      offer_ply(1'b0, 16'shFFFF, OC_WIN, 1'b0, 1'b0);
      offer_ply(1'b0, 16'sh0001, OC_WIN, 1'b1, 1'b1);
      settle();

      // Lambda above 1.0 behaves as 1.0
      write_lambda(17'h1FFFF);
      offer_ply(1'b1, 16'sh4000, OC_DRAW, 1'b0, 1'b0);
      offer_ply(1'b0, 16'shC000, OC_WIN, 1'b1, 1'b0);
      offer_ply(1'b1, 16'sh1234, OC_LOSS, 1'b1, 1'b1);
      settle();

      // Half lambda, mixed movers
      write_lambda(17'd32768);
      offer_ply(1'b0, 16'sh7FFF, OC_LOSS, 1'b1, 1'b0);
      offer_ply(1'b1, 16'sh7FFF, OC_WIN, 1'b0, 1'b0);
      offer_ply(1'b1, 16'sh8000, OC_BAD, 1'b1, 1'b0);
      offer_ply(1'b0, 16'sh8001, OC_DRAW, 1'b0, 1'b0);
      offer_ply(1'b0, 16'sh3FFF, OC_LOSS, 1'b1, 1'b0);
      offer_ply(1'b1, 16'shC001, OC_WIN, 1'b0, 1'b1);
      settle();

      // Random phases: lambda set while idle, then a few games; first game overflows the store
      while (plies_sent < RANDOM_PLIES - 20) begin
         write_lambda(pick_lambda());
         calm       = ($urandom_range(0, 3) == 0);
         games_left = $urandom_range(1, 4);
         while (games_left > 0) begin
            random_game(pick_length(first));
            first = 1'b0;
            games_left--;
         end
         settle();
      end
      req_ch.valid <= 1'b0;

      // Drain, then leave room for any stray label
      while (board.pending() != 0) @(posedge clock);
      repeat (2 * PLY_SLOTS + 8) @(posedge clock);
      if (board.pending() != 0) begin
         board.errors += board.pending();
         $display("%0t: %0d labels never arrived", $time, board.pending());
      end

      $display("Covered %0d games from %0d ply requests (%0d beyond store capacity),",
               board.games, plies_sent, board.plies_dropped);
      $display("%0d labels compared across %0d lambda settings.",
               board.labels_checked, lambda_writes);
      if (board.errors == 0) begin
         $display("td_lambda_return_labeler_tb OK");
      end else begin
         $display("td_lambda_return_labeler_tb NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
design/tdlr_pkg.sv
design/tdlr_if.sv
design/tdlr_ram.sv
design/tdlr_ctrl.sv
design/tdlr_dp.sv
design/td_lambda_return_labeler.sv
verif/td_lambda_return_labeler_tb.sv
